FILE: rtl/lpmd_pkg.sv
// lpmd_pkg: shared types and constants for the length-prefixed message deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lpmd_pkg;

  // header layout: destination, length, tag, 32-bit little-endian words
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned HDR_STORE_W  = (HEADER_BYTES - 1) * 8;
  localparam logic [3:0]  HDR_LAST     = 4'(HEADER_BYTES - 1);

  // status codes carried on m_tuser
  localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] destination;
    logic [31:0] message_tag;
    logic [30:0] message_length;
    logic [7:0]  payload_byte;
    logic        last_of_message;
  } lpmd_result_t;

endpackage

FILE: rtl/lpmd_parse.sv
// lpmd_parse: header collection, payload count-down and result decision
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           thread_count,
  output logic                  res_valid,
  output lpmd_pkg::lpmd_result_t res
);
  import lpmd_pkg::*;

  logic [3:0]             header_count;
  logic [HDR_STORE_W-1:0] header_store;
  logic                   in_payload;
  logic [30:0]            bytes_left;
  logic                   drop_message;
  logic [31:0]            cur_dest;
  logic [31:0]            cur_tag;
  logic [30:0]            cur_len;

  logic [HDR_STORE_W+7:0] full_hdr;
  logic [31:0]            new_dest;
  logic [31:0]            new_len;
  logic [31:0]            new_tag;
  logic                   dest_ok;
  logic                   hdr_done;

  assign full_hdr = {data_byte, header_store};
  assign new_dest = full_hdr[31:0];
  assign new_len  = full_hdr[63:32];
  assign new_tag  = full_hdr[95:64];
  assign dest_ok  = (new_dest[31:16] == 16'd0) && (new_dest[15:0] < thread_count);
  assign hdr_done = !in_payload && (header_count == HDR_LAST);

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (in_payload) begin
      res_valid           = !drop_message;
      res.status          = STATUS_PAYLOAD;
      res.destination     = cur_dest;
      res.message_tag     = cur_tag;
      res.message_length  = cur_len;
      res.payload_byte    = data_byte;
      res.last_of_message = (bytes_left == 31'd1);
    end else if (hdr_done) begin
      res.destination     = new_dest;
      res.message_tag     = new_tag;
      res.last_of_message = 1'b1;
      if (new_len[31]) begin
        res_valid  = 1'b1;
        res.status = STATUS_BAD_LEN;
      end else begin
        res_valid  = dest_ok && (new_len == 32'd0);
        res.status = STATUS_EMPTY;
      end
    end
    res_valid = res_valid && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      header_store <= '0;
      in_payload   <= 1'b0;
      bytes_left   <= '0;
      drop_message <= 1'b0;
      cur_dest     <= '0;
      cur_tag      <= '0;
      cur_len      <= '0;
    end else if (fire) begin
      if (in_payload) begin
        bytes_left <= bytes_left - 31'd1;
        if (bytes_left == 31'd1) begin
          in_payload <= 1'b0;
        end
      end else if (!hdr_done) begin
        // shift in: byte 0 ends up lowest once the header is full
        header_store <= full_hdr[HDR_STORE_W+7:8];
        header_count <= header_count + 4'd1;
      end else begin
        header_count <= '0;
        header_store <= full_hdr[HDR_STORE_W+7:8];
        cur_dest     <= new_dest;
        cur_tag      <= new_tag;
        cur_len      <= new_len[30:0];
        if (!new_len[31]) begin
          drop_message <= !dest_ok;
          if (new_len != 32'd0) begin
            in_payload <= 1'b1;
            bytes_left <= new_len[30:0];
          end
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_hdr_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= HDR_LAST)
    else $error("header count past last header byte");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (bytes_left != 31'd0))
    else $error("payload phase with nothing left");

  a_payload_hdr_idle: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (header_count == 4'd0))
    else $error("header bytes collected during payload");

  a_last_ends_payload: assert property (@(posedge clk) disable iff (rst)
    (fire && in_payload && bytes_left == 31'd1) |=> !in_payload)
    else $error("payload phase did not end on last byte");
`endif

endmodule

FILE: rtl/lpmd_out_reg.sv
// lpmd_out_reg: result register on the master side
// depends on lpmd_pkg
`timescale 1ns / 1ps

module lpmd_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  lpmd_pkg::lpmd_result_t res,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output lpmd_pkg::lpmd_result_t held,
  output logic                  advance
);
  import lpmd_pkg::*;

  // slot is free when empty or drained in this cycle
  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

FILE: rtl/length_prefixed_message_deframer_top.sv
// length_prefixed_message_deframer_top: byte stream in, per-byte message results out
// depends on lpmd_pkg, lpmd_parse, lpmd_out_reg
`timescale 1ns / 1ps
//
//  channel  dir  handshake           contents
//  s_*      in   s_tvalid/s_tready   one stream byte per request
//  m_*      out  m_tvalid/m_tready   one result per request: tdata words, tuser status,
//                                    tlast end of message
//  cfg_*    in   cfg_we              thread_count write, taken on any cycle with cfg_we
//
//  one byte per cycle while the m side is not stalled; a byte passes the input register,
//  then decision logic into the result register, before m_tvalid rises
//  header bytes, bar the last of a bad-length or valid empty header, and dropped payload
//  bytes leave no result; like payload bytes they wait in the input register while a result is stalled
//  a stalled m side holds the result; the input register keeps one more byte,
//  then s_tready drops
//  rst is synchronous: header collection restarts, thread_count returns to 5

module length_prefixed_message_deframer_top (
  input  logic         clk,
  input  logic         rst,
  // slave side
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  // master side
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // [31:0] destination, [63:32] message_tag,
                                  // [94:64] message_length, [102:95] payload_byte,
                                  // [103] zero
  output logic [1:0]   m_tuser,   // [1:0] status
  output logic         m_tlast,   // last_of_message
  // configuration
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata  // thread_count
);
  import lpmd_pkg::*;

  logic [15:0]  thread_count;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  logic         fire;
  logic         res_valid;
  lpmd_result_t res;
  lpmd_result_t held;

  // input register takes a byte when empty or when its byte moves on
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // number of existing destinations
  always_ff @(posedge clk) begin
    if (rst) begin
      thread_count <= 16'd5;
    end else if (cfg_we) begin
      thread_count <= cfg_wdata;
    end
  end

  lpmd_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .data_byte    (in_byte),
    .thread_count (thread_count),
    .res_valid    (res_valid),
    .res          (res)
  );

  lpmd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .held     (held),
    .advance  (advance)
  );

  assign m_tdata = {1'b0, held.payload_byte, held.message_length,
                    held.message_tag, held.destination};
  assign m_tuser = held.status;
  assign m_tlast = held.last_of_message;

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && in_valid) |-> !s_tready)
    else $error("input taken while both stages are full");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> advance)
    else $error("result loaded over a pending request");

  a_no_result_without_byte: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> ($past(m_tvalid && !m_tready) || !$rose(m_tvalid)))
    else $error("result appeared without an input byte");
`endif

endmodule
